@@ design/uvs_pkg.sv @@
// shared types and constants of the uv sphere mesh generator
package uvs_pkg;

  localparam int MAX_RINGS_DEF       = 256;
  localparam int MAX_SECTORS_DEF     = 256;
  localparam int COORD_FRAC_BITS_DEF = 14;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_REJECT   = 2'd2;

  localparam logic CFG_RING_COUNT   = 1'b0;
  localparam logic CFG_SECTOR_COUNT = 1'b1;

  // odd sine polynomial coefficients, q30
  localparam logic [30:0] POLY_C1  = 31'd1686629713;
  localparam logic [30:0] POLY_C3  = 31'd693598669;
  localparam logic [30:0] POLY_C5  = 31'd85569304;
  localparam logic [30:0] POLY_C7  = 31'd5026995;
  localparam logic [30:0] POLY_C9  = 31'd172272;
  localparam logic [30:0] POLY_C11 = 31'd3864;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // per-word payload of one output result
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic        last;
  } result_t;

endpackage

@@ design/uvs_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
module uvs_divider #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 10,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] tag_out
);

  logic [NUM_W:0]   vld;
  logic [DEN_W:0]   rem [NUM_W+1];
  logic [NUM_W-1:0] qq  [NUM_W+1];
  logic [DEN_W-1:0] dd  [NUM_W+1];
  logic [TAG_W-1:0] tg  [NUM_W+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign qq[0]  = num;
  assign dd[0]  = den;
  assign tg[0]  = tag_in;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] shifted;
    always_comb begin
      shifted = {rem[k], qq[k][NUM_W-1]};
      trial   = shifted - {2'b00, dd[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[DEN_W+1]) begin
          rem[k+1] <= trial[DEN_W:0];
          qq[k+1]  <= {qq[k][NUM_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= shifted[DEN_W:0];
          qq[k+1]  <= {qq[k][NUM_W-2:0], 1'b0};
        end
        dd[k+1] <= dd[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = qq[NUM_W];
  assign tag_out   = tg[NUM_W];

endmodule

@@ design/uvs_sine.sv @@
// pipelined q30 sine of a 32-bit phase, at most one multiply per stage
module uvs_sine #(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      phase,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [31:0]      sin_out,
  output logic [TAG_W-1:0] tag_out
);

  localparam int NS = 8;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  logic [NS:0]      vld;
  logic [30:0]      t   [NS+1];
  logic [30:0]      t2  [NS+1];
  logic [30:0]      h   [NS+1];
  logic             neg [NS+1];
  logic [TAG_W-1:0] tg  [NS+1];

  logic [30:0] t_in;
  logic [61:0] sq;
  logic [61:0] hp [5];
  logic [61:0] mp;
  logic [31:0] m;

  always_comb begin
    t_in = {1'b0, phase[29:0]};
    if (phase[30]) begin
      t_in = 31'(ONE_Q30[30:0] - {1'b0, phase[29:0]});
    end
  end

  assign vld[0] = in_valid;
  assign t[0]   = t_in;
  assign t2[0]  = '0;
  assign h[0]   = uvs_pkg::POLY_C11;
  assign neg[0] = phase[31];
  assign tg[0]  = tag_in;

  assign sq = 62'(t[1]) * 62'(t[1]);

  always_comb begin
    hp[0] = 62'(h[2]) * 62'(t2[2]);
    hp[1] = 62'(h[3]) * 62'(t2[3]);
    hp[2] = 62'(h[4]) * 62'(t2[4]);
    hp[3] = 62'(h[5]) * 62'(t2[5]);
    hp[4] = 62'(h[6]) * 62'(t2[6]);
    mp    = 62'(h[7]) * 62'(t[7]);
    m     = 32'(mp >> 30);
    if (m > uvs_pkg::ONE_Q30) begin
      m = uvs_pkg::ONE_Q30;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        t[k+1]   <= t[k];
        neg[k+1] <= neg[k];
        tg[k+1]  <= tg[k];
        if (k == 1) begin
          t2[k+1] <= 31'(sq >> 30);
        end else begin
          t2[k+1] <= t2[k];
        end
        case (k)
          2: h[k+1] <= 31'(uvs_pkg::POLY_C9 - 31'(hp[0] >> 30));
          3: h[k+1] <= 31'(uvs_pkg::POLY_C7 - 31'(hp[1] >> 30));
          4: h[k+1] <= 31'(uvs_pkg::POLY_C5 - 31'(hp[2] >> 30));
          5: h[k+1] <= 31'(uvs_pkg::POLY_C3 - 31'(hp[3] >> 30));
          6: h[k+1] <= 31'(uvs_pkg::POLY_C1 - 31'(hp[4] >> 30));
          7: h[k+1] <= 31'(m);
          default: h[k+1] <= h[k];
        endcase
      end
    end
  end

  assign out_valid = vld[NS];
  assign sin_out   = neg[NS] ? 32'(-{1'b0, h[NS]}) : {1'b0, h[NS]};
  assign tag_out   = tg[NS];

endmodule

@@ design/uv_sphere_mesh_generator.sv @@
// top level: uv sphere grid point to vertex and triangle words
// pipeline: a point passes 42 divider, 8 sine, product, index and output stages
// before its first result word can leave
// a point inside a cell sends a vertex and two triangle words through one shared
// output word register; rejected and edge points send one word
// the pipeline stalls as a whole when the output is held or the tail has words left
// reset: synchronous active-high, registers return to 16 rings and 16 sectors
module uv_sphere_mesh_generator #(
  parameter int MAX_RINGS       = uvs_pkg::MAX_RINGS_DEF,
  parameter int MAX_SECTORS     = uvs_pkg::MAX_SECTORS_DEF,
  parameter int COORD_FRAC_BITS = uvs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ring_index,
  input  logic [7:0]  sector_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] pos_z,
  output logic [15:0] tex_u,
  output logic [15:0] tex_v,
  output logic [15:0] corner_a,
  output logic [15:0] corner_b,
  output logic [15:0] corner_c,
  output logic        last
);

  localparam int XY_SH = 60 - COORD_FRAC_BITS;
  localparam int Z_SH  = 30 - COORD_FRAC_BITS;

  logic [8:0] ring_count;
  logic [8:0] sector_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count   <= 9'd16;
      sector_count <= 9'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        uvs_pkg::CFG_RING_COUNT:   ring_count   <= cfg_data;
        uvs_pkg::CFG_SECTOR_COUNT: sector_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // item tag: ring, sector, reject flag
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] s;
    logic       rej;
  } tag_t;

  // whole pipe advances when its tail can leave
  logic en;
  logic tail_valid;
  logic tail_go;

  // input decode
  logic rej_in;
  logic [8:0] rm1, sm1;
  always_comb begin
    rm1 = ring_count - 9'd1;
    sm1 = sector_count - 9'd1;
    rej_in = (ring_count < 9'd2) || (32'(ring_count) > MAX_RINGS) ||
             (sector_count < 9'd2) || (32'(sector_count) > MAX_SECTORS) ||
             ({1'b0, ring_index} >= ring_count) ||
             ({1'b0, sector_index} >= sector_count);
    if (rej_in) begin
      rm1 = 9'd1;
      sm1 = 9'd1;
    end
  end

  tag_t tag_in;
  assign tag_in = '{r: ring_index, s: sector_index, rej: rej_in};

  // phase dividers: (idx*2^(sh+1)+2den) / (2den), that is floor(idx*2^sh/den) + 1
  logic [41:0] th_num, ph_num;
  logic [9:0]  rden, sden;
  assign rden   = {rm1, 1'b0};
  assign sden   = {sm1, 1'b0};
  assign th_num = (42'(ring_index) << 32) + 42'(rden);
  assign ph_num = (42'(sector_index) << 33) + 42'(sden);

  logic        dv_th, dv_ph;
  logic [41:0] q_th, q_ph;
  tag_t        tg_th, tg_ph;

  uvs_divider #(.NUM_W(42), .DEN_W(10), .TAG_W($bits(tag_t))) u_div_th (
    .clk, .rst, .en, .in_valid(in_valid && in_ready), .num(th_num), .den(rden),
    .tag_in(tag_in), .out_valid(dv_th), .quo(q_th), .tag_out(tg_th)
  );
  uvs_divider #(.NUM_W(42), .DEN_W(10), .TAG_W($bits(tag_t))) u_div_ph (
    .clk, .rst, .en, .in_valid(in_valid && in_ready), .num(ph_num), .den(sden),
    .tag_in(tag_in), .out_valid(dv_ph), .quo(q_ph), .tag_out(tg_ph)
  );

  logic [31:0] th, ph;
  assign th = q_th[31:0];
  assign ph = q_ph[31:0];

  // four sine pipes
  logic        sv0, sv1, sv2, sv3;
  logic [31:0] st, ct, sp, cp;
  tag_t        tg_s, tg_u1, tg_u2, tg_u3;

  uvs_sine #(.TAG_W($bits(tag_t))) u_sin_th (
    .clk, .rst, .en, .in_valid(dv_th), .phase(th), .tag_in(tg_th),
    .out_valid(sv0), .sin_out(st), .tag_out(tg_s)
  );
  uvs_sine #(.TAG_W($bits(tag_t))) u_cos_th (
    .clk, .rst, .en, .in_valid(dv_th), .phase(th - 32'h4000_0000), .tag_in(tg_th),
    .out_valid(sv1), .sin_out(ct), .tag_out(tg_u1)
  );
  uvs_sine #(.TAG_W($bits(tag_t))) u_sin_ph (
    .clk, .rst, .en, .in_valid(dv_ph), .phase(ph), .tag_in(tg_ph),
    .out_valid(sv2), .sin_out(sp), .tag_out(tg_u2)
  );
  uvs_sine #(.TAG_W($bits(tag_t))) u_cos_ph (
    .clk, .rst, .en, .in_valid(dv_ph), .phase(ph + 32'h4000_0000), .tag_in(tg_ph),
    .out_valid(sv3), .sin_out(cp), .tag_out(tg_u3)
  );

  // texture coords track the phases: u = round(s*2^15/(sc-1)) = phase >> 17 rounded
  // computed exactly from the phase quotient using the same divider bits
  logic [15:0] u_t, v_t;
  assign u_t = 16'(q_ph[41:17] + 25'(q_ph[16]));
  assign v_t = 16'(q_th[41:16] + 26'(q_th[15]));

  // texture delay line aligned with the sine pipes
  localparam int SD = 8;
  logic [15:0] u_d [SD+1];
  logic [15:0] v_d [SD+1];
  assign u_d[0] = u_t;
  assign v_d[0] = v_t;
  for (genvar k = 0; k < SD; k++) begin : g_tex
    always_ff @(posedge clk) begin
      if (en) begin
        u_d[k+1] <= u_d[k];
        v_d[k+1] <= v_d[k];
      end
    end
  end

  // product stage
  logic        pv;
  tag_t        tg_p;
  logic signed [63:0] px, py;
  logic signed [31:0] pz;
  logic [15:0] pu, pv_t;
  logic [8:0]  p_sc, p_rc;
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= sv0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px   <= 64'($signed(cp)) * 64'($signed(st));
      py   <= 64'($signed(sp)) * 64'($signed(st));
      pz   <= $signed(ct);
      tg_p <= tg_s;
      pu   <= u_d[SD];
      pv_t <= v_d[SD];
    end
  end
  assign p_sc = sector_count;
  assign p_rc = ring_count;

  function automatic logic [15:0] rnd64(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? 16'(-mag) : 16'(mag);
  endfunction

  // index stage: row-major corner indices
  logic        iv;
  tag_t        tg_i;
  logic [15:0] ix, iy, iz, iu, ivv;
  logic [15:0] ia, id;
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (en) begin
      iv <= pv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tg_i <= tg_p;
      ix   <= rnd64(px, XY_SH);
      iy   <= rnd64(py, XY_SH);
      iz   <= rnd64(64'(pz), Z_SH);
      iu   <= pu;
      ivv  <= pv_t;
      ia   <= 16'(tg_p.r * p_sc + 16'(tg_p.s));
      id   <= 16'((tg_p.r + 9'd1) * p_sc + 16'(tg_p.s));
    end
  end

  // emitter: sends up to three words from the tail register
  logic [1:0] phase_cnt;
  logic       in_cell;
  uvs_pkg::result_t res;
  assign tail_valid = iv;
  assign in_cell = ({1'b0, tg_i.r} < p_rc - 9'd1) && ({1'b0, tg_i.s} < p_sc - 9'd1);

  always_comb begin
    res = '0;
    if (tg_i.rej) begin
      res.kind = uvs_pkg::KIND_REJECT;
      res.last = 1'b1;
    end else if (phase_cnt == 2'd0) begin
      res.kind  = uvs_pkg::KIND_VERTEX;
      res.pos_x = ix;
      res.pos_y = iy;
      res.pos_z = iz;
      res.tex_u = iu;
      res.tex_v = ivv;
      res.last  = !in_cell;
    end else if (phase_cnt == 2'd1) begin
      res.kind     = uvs_pkg::KIND_TRIANGLE;
      res.corner_a = ia;
      res.corner_b = ia + 16'd1;
      res.corner_c = id + 16'd1;
    end else begin
      res.kind     = uvs_pkg::KIND_TRIANGLE;
      res.corner_a = ia;
      res.corner_b = id + 16'd1;
      res.corner_c = id;
      res.last     = 1'b1;
    end
  end

  // output word register
  uvs_pkg::result_t out_q;
  logic out_full;
  logic push;
  assign push    = tail_valid && (!out_full || out_ready);
  assign tail_go = push && res.last;
  assign en      = !tail_valid || tail_go;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      phase_cnt <= 2'd0;
    end else begin
      if (push) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
      if (push) begin
        phase_cnt <= res.last ? 2'd0 : phase_cnt + 2'd1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (push) begin
      out_q <= res;
    end
  end

  assign out_valid = out_full;
  assign kind      = out_q.kind;
  assign pos_x     = out_q.pos_x;
  assign pos_y     = out_q.pos_y;
  assign pos_z     = out_q.pos_z;
  assign tex_u     = out_q.tex_u;
  assign tex_v     = out_q.tex_v;
  assign corner_a  = out_q.corner_a;
  assign corner_b  = out_q.corner_b;
  assign corner_c  = out_q.corner_c;
  assign last      = out_q.last;

  // unused valid flags and tags from the paired pipes
  logic unused_ok;
  assign unused_ok = sv1 ^ sv2 ^ sv3 ^ dv_ph ^ (|tg_u1) ^ (|tg_u2) ^ (|tg_u3) ^ (|tg_ph);

endmodule

@@ tb/sv/uv_sphere_mesh_generator_tb.sv @@
// testbench of the uv sphere mesh generator: directed and random grid points
module uv_sphere_mesh_generator_tb;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_data;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ring_index = '0;
  logic [7:0]  sector_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [15:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic [15:0] corner_a, corner_b, corner_c;
  logic        last;

  uv_sphere_mesh_generator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .ring_index(ring_index), .sector_index(sector_index),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u),
    .tex_v(tex_v), .corner_a(corner_a), .corner_b(corner_b),
    .corner_c(corner_c), .last(last)
  );

  // grid points waiting for the driver, as {ring, sector}
  logic [15:0] point_queue[$];
  // expected output words, oldest first
  uvs_pkg::result_t expected_words[$];
  // grid size as the predictor sees it
  logic [8:0]  grid_rings;
  logic [8:0]  grid_sectors;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LAT_CYCLES  = 80;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gap length: mostly zero or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_point(logic [15:0] p);
    point_queue.insert(point_queue.size(), p);
  endtask

  task automatic expect_word(uvs_pkg::result_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  // q30 sine of a phase in units of 2^-32 of a turn
  function automatic longint sine_q30(logic [31:0] phase);
    logic [63:0] t, t2, h, m;
    logic [63:0] coef[6];
    coef[0] = 64'(uvs_pkg::POLY_C1);  coef[1] = 64'(uvs_pkg::POLY_C3);
    coef[2] = 64'(uvs_pkg::POLY_C5);  coef[3] = 64'(uvs_pkg::POLY_C7);
    coef[4] = 64'(uvs_pkg::POLY_C9);  coef[5] = 64'(uvs_pkg::POLY_C11);
    t = {34'd0, phase[29:0]};
    if (phase[30]) t = 64'h4000_0000 - t;
    t2 = (t * t) >> 30;
    h = coef[5];
    for (int k = 4; k >= 0; k--) h = coef[k] - ((h * t2) >> 30);
    m = (h * t) >> 30;
    if (m > 64'h4000_0000) m = 64'h4000_0000;
    return phase[31] ? -longint'(m) : longint'(m);
  endfunction

  // round half away from zero, keep 16 bits
  function automatic logic [15:0] round_away(longint v, int sh);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) m = -m;
    return m[15:0];
  endfunction

  function automatic logic [63:0] scaled_ratio(logic [63:0] num, int sh,
                                               logic [63:0] den);
    return ((num << sh) + den / 2) / den;
  endfunction

  // expected words of one grid point under the current grid size
  task automatic predict_point(logic [7:0] r8, logic [7:0] s8);
    uvs_pkg::result_t w;
    logic [63:0] r, s, rc, sc, a, b, c, d;
    logic [31:0] th, ph;
    longint      st, zc, sp, cp;
    bit          in_cell;
    r = 64'(r8); s = 64'(s8); rc = 64'(grid_rings); sc = 64'(grid_sectors);
    w = '0;
    if (rc < 2 || rc > 256 || sc < 2 || sc > 256 || r >= rc || s >= sc) begin
      w.kind = uvs_pkg::KIND_REJECT;
      w.last = 1'b1;
      expect_word(w);
      return;
    end
    th = 32'(scaled_ratio(r, 31, rc - 1));
    ph = 32'(scaled_ratio(s, 32, sc - 1));
    st = sine_q30(th);
    zc = sine_q30(th - 32'h4000_0000);
    sp = sine_q30(ph);
    cp = sine_q30(ph + 32'h4000_0000);
    in_cell = (r < rc - 1) && (s < sc - 1);
    w.kind  = uvs_pkg::KIND_VERTEX;
    w.pos_x = round_away(cp * st, 46);
    w.pos_y = round_away(sp * st, 46);
    w.pos_z = round_away(zc, 16);
    w.tex_u = 16'(scaled_ratio(s, 15, sc - 1));
    w.tex_v = 16'(scaled_ratio(r, 15, rc - 1));
    w.last  = !in_cell;
    expect_word(w);
    if (!in_cell) return;
    a = r * sc + s;
    b = a + 1;
    c = (r + 1) * sc + s + 1;
    d = (r + 1) * sc + s;
    w = '0;
    w.kind = uvs_pkg::KIND_TRIANGLE;
    w.corner_a = a[15:0]; w.corner_b = b[15:0]; w.corner_c = c[15:0];
    expect_word(w);
    w.corner_b = c[15:0]; w.corner_c = d[15:0]; w.last = 1'b1;
    expect_word(w);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    fail_count++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d",
             what, got, want, cycle_count);
  endtask

  // driver: one point from the queue, prediction when it is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_point(ring_index, sector_index);
        if (point_queue.size() > 0 && pick_gap() == 0) begin
          {ring_index, sector_index} <= point_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
          send_gap <= pick_gap();
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (point_queue.size() > 0) begin
          {ring_index, sector_index} <= point_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each output word with the oldest expectation
  always @(posedge clk) begin
    uvs_pkg::result_t w;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word kind", {14'd0, kind}, 16'd0);
        end else begin
          w = expected_words.pop_front();
          if (kind !== w.kind) report_mismatch("kind", {14'd0, kind}, {14'd0, w.kind});
          if (pos_x !== w.pos_x) report_mismatch("pos_x", pos_x, w.pos_x);
          if (pos_y !== w.pos_y) report_mismatch("pos_y", pos_y, w.pos_y);
          if (pos_z !== w.pos_z) report_mismatch("pos_z", pos_z, w.pos_z);
          if (tex_u !== w.tex_u) report_mismatch("tex_u", tex_u, w.tex_u);
          if (tex_v !== w.tex_v) report_mismatch("tex_v", tex_v, w.tex_v);
          if (corner_a !== w.corner_a) report_mismatch("corner_a", corner_a, w.corner_a);
          if (corner_b !== w.corner_b) report_mismatch("corner_b", corner_b, w.corner_b);
          if (corner_c !== w.corner_c) report_mismatch("corner_c", corner_c, w.corner_c);
          if (last !== w.last) report_mismatch("last", {15'd0, last}, {15'd0, w.last});
        end
      end
      // ready toggles in random stretches
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_gap  <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait until the block has drained, plus a margin of LAT_CYCLES
  task automatic wait_drained();
    while (point_queue.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid(logic [8:0] rings, logic [8:0] sectors);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= uvs_pkg::CFG_RING_COUNT; cfg_data <= rings;
    @(posedge clk);
    cfg_index <= uvs_pkg::CFG_SECTOR_COUNT; cfg_data <= sectors;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_rings   = rings;
    grid_sectors = sectors;
  endtask

  // mostly in-grid points, some out of range, some anywhere
  task automatic queue_random(int n);
    int rmax, smax, p;
    for (int i = 0; i < n; i++) begin
      rmax = (grid_rings > 256 || grid_rings == 0) ? 255 : int'(grid_rings) - 1;
      smax = (grid_sectors > 256 || grid_sectors == 0) ? 255 : int'(grid_sectors) - 1;
      p = $urandom_range(0, 9);
      if (p < 7)
        queue_point({8'($urandom_range(0, rmax)), 8'($urandom_range(0, smax))});
      else
        queue_point(16'($urandom));
    end
  endtask

  initial begin
    logic [8:0] sizes[$];
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = uvs_pkg::CFG_RING_COUNT; cfg_data = '0;
    grid_rings = 9'd16; grid_sectors = 9'd16;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed at reset size: corners, poles, seam, out of grid
    queue_point({8'd0, 8'd0});
    queue_point({8'd15, 8'd15});
    queue_point({8'd15, 8'd0});
    queue_point({8'd0, 8'd15});
    queue_point({8'd7, 8'd4});
    queue_point({8'd16, 8'd3});
    queue_point({8'd3, 8'd16});
    queue_point({8'd255, 8'd255});
    queue_point({8'd170, 8'd85});
    wait_drained();

    // largest grid: corner indices up to the 16-bit limit near the far corner
    write_grid(9'd256, 9'd256);
    queue_point({8'd254, 8'd254});
    queue_point({8'd255, 8'd255});
    queue_point({8'd128, 8'd64});
    queue_point({8'd0, 8'd255});
    wait_drained();

    // smallest grid and bad sizes
    write_grid(9'd2, 9'd2);
    queue_point({8'd0, 8'd0});
    queue_point({8'd1, 8'd1});
    queue_point({8'd2, 8'd0});
    wait_drained();
    write_grid(9'd1, 9'd300);
    queue_point({8'd0, 8'd0});
    wait_drained();
    write_grid(9'd511, 9'd0);
    queue_point({8'd0, 8'd0});
    queue_point({8'd5, 8'd5});
    wait_drained();

    // random phases over several grid sizes
    sizes = '{9'd16, 9'd2, 9'd256, 9'd3, 9'd37, 9'd100, 9'd200, 9'd257};
    foreach (sizes[i]) begin
      write_grid(sizes[i], 9'($urandom_range(2, 256)));
      queue_random(58);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
